### hw/rtl/rrbc_pkg.sv
// Shared types and constants for the ROM/RAM bank controller.
package rrbc_pkg;

    localparam int RAM_BANK_BITS_DEF = 13;
    localparam int RAM_BANKS_DEF     = 4;

    localparam int ROM_ADDR_W = 21;
    localparam int BUS_ADDR_W = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_ROM_READ = 2'd0,
        OP_REG_WRITE = 2'd1,
        OP_RAM_READ = 2'd2,
        OP_RAM_WRITE = 2'd3
    } op_t;

    // Result of one access, except the byte that comes back from the RAM.
    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  rom_fetch;
        logic                  unmapped;
        logic                  from_ram;
        logic [BYTE_W-1:0]     fixed_data;
    } bank_res_t;

endpackage

### hw/rtl/rrbc_ram.sv
// Cartridge RAM: single-port synchronous memory with a registered read.
module rrbc_ram #(
    parameter int DEPTH = 32768,
    parameter int IDX_W = 15
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [IDX_W-1:0] index,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[index] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[index];
        end
    end

endmodule

### hw/rtl/rrbc_bank.sv
// Bank registers, configuration registers and address translation.
module rrbc_bank #(
    parameter int RAM_BANK_BITS = 13,
    parameter int RAM_BANKS     = 4,
    parameter int IDX_W         = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rrbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  rrbc_pkg::op_t                  opcode,
    input  logic [rrbc_pkg::BUS_ADDR_W-1:0] address,
    input  logic [rrbc_pkg::BYTE_W-1:0]     write_data,
    output rrbc_pkg::bank_res_t            res,
    output logic                           ram_we,
    output logic                           ram_re,
    output logic [IDX_W-1:0]               ram_index
);

    import rrbc_pkg::*;

    localparam logic [BUS_ADDR_W-1:0] RAM_EN_LAST   = 16'h1fff;
    localparam logic [BUS_ADDR_W-1:0] ROM_BANK_LAST = 16'h3fff;
    localparam logic [BUS_ADDR_W-1:0] UPPER_LAST    = 16'h5fff;
    localparam logic [BUS_ADDR_W-1:0] MODE_LAST     = 16'h7fff;
    localparam logic [BUS_ADDR_W-1:0] HIGH_WINDOW   = 16'h4000;

    localparam logic [2:0] RAM_BANKS_C = 3'(RAM_BANKS);

    logic [3:0] rom_size_code_reg, rom_size_code_next;
    logic [2:0] ram_size_code_reg, ram_size_code_next;
    logic       ram_on_reg, ram_on_next;
    logic [6:0] rom_bank_reg, rom_bank_next;
    logic [1:0] ram_bank_reg, ram_bank_next;
    logic       mode_reg, mode_next;

    logic [3:0] code_clamped;
    logic [9:0] bank_mask;
    logic [4:0] low_bits;
    logic [1:0] hi_bank_bits;
    logic [6:0] read_bank;
    logic [1:0] ram_bank_sel;

    always_comb
    begin
        code_clamped = (rom_size_code_reg > 4'd8) ? 4'd8 : rom_size_code_reg;
        bank_mask    = (10'd2 << code_clamped) - 10'd1;
        low_bits     = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
        hi_bank_bits = (code_clamped == 4'd5) ? {1'b0, write_data[0]} : write_data[1:0];

        if (!mode_reg || RAM_BANKS == 1)
        begin
            ram_bank_sel = 2'd0;
        end
        else if ({1'b0, ram_bank_reg} >= RAM_BANKS_C)
        begin
            ram_bank_sel = 2'((3'({1'b0, ram_bank_reg}) - RAM_BANKS_C));
        end
        else
        begin
            ram_bank_sel = ram_bank_reg;
        end

        ram_index = IDX_W'({ram_bank_sel, address[RAM_BANK_BITS-1:0]});
        ram_we    = accept && (opcode == OP_RAM_WRITE) && ram_on_reg;
        ram_re    = accept && (opcode == OP_RAM_READ) && ram_on_reg;

        if (address < HIGH_WINDOW)
        begin
            read_bank = mode_reg ? (rom_bank_reg & 7'h60) : 7'd0;
        end
        else
        begin
            read_bank = rom_bank_reg;
        end

        res.rom_address = '0;
        res.rom_fetch   = 1'b0;
        res.unmapped    = 1'b0;
        res.from_ram    = 1'b0;
        res.fixed_data  = '0;

        rom_size_code_next = rom_size_code_reg;
        ram_size_code_next = ram_size_code_reg;
        ram_on_next        = ram_on_reg;
        rom_bank_next      = rom_bank_reg;
        ram_bank_next      = ram_bank_reg;
        mode_next          = mode_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_ROM_SIZE)
            begin
                rom_size_code_next = cfg_data;
            end
            else if (cfg_index == CFG_RAM_SIZE)
            begin
                ram_size_code_next = cfg_data[2:0];
            end
        end

        case (opcode)
            OP_ROM_READ:
            begin
                res.rom_address = {read_bank, address[13:0]};
                res.rom_fetch   = 1'b1;
            end
            OP_REG_WRITE:
            begin
                if (address <= RAM_EN_LAST)
                begin
                    if (accept)
                    begin
                        ram_on_next = (write_data[3:0] == 4'ha);
                    end
                end
                else if (address <= ROM_BANK_LAST)
                begin
                    if (accept)
                    begin
                        rom_bank_next = ((rom_bank_reg & 7'h60) | {2'b00, low_bits})
                                        & bank_mask[6:0];
                    end
                end
                else if (address <= UPPER_LAST)
                begin
                    if (accept && code_clamped >= 4'd5)
                    begin
                        rom_bank_next = {hi_bank_bits, rom_bank_reg[4:0]};
                    end
                    if (accept && (ram_size_code_reg inside {[3'd3:3'd5]}))
                    begin
                        ram_bank_next = write_data[1:0];
                    end
                end
                else if (address <= MODE_LAST)
                begin
                    if (accept)
                    begin
                        mode_next = write_data[0];
                    end
                end
                else
                begin
                    res.unmapped = 1'b1;
                end
            end
            OP_RAM_READ:
            begin
                res.from_ram   = ram_on_reg;
                res.fixed_data = ram_on_reg ? 8'h00 : 8'hff;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_code_reg <= '0;
            ram_size_code_reg <= '0;
            ram_on_reg        <= 1'b0;
            rom_bank_reg      <= 7'd1;
            ram_bank_reg      <= '0;
            mode_reg          <= 1'b0;
        end
        else
        begin
            rom_size_code_reg <= rom_size_code_next;
            ram_size_code_reg <= ram_size_code_next;
            ram_on_reg        <= ram_on_next;
            rom_bank_reg      <= rom_bank_next;
            ram_bank_reg      <= ram_bank_next;
            mode_reg          <= mode_next;
        end
    end

endmodule

### hw/rtl/rom_ram_bank_controller.sv
// Top level of the ROM/RAM bank controller with its stream handshake.
//
// Each input beat on s_* is one CPU bus access: a ROM read, a bank register
// write, a cartridge RAM read or a cartridge RAM write. Each access yields
// exactly one output beat on m_* carrying the translated ROM address, the
// fetch flag, the read byte and the unmapped flag.
// Register writes and RAM writes take effect at the edge that accepts the beat.
// m_tvalid rises once the output register is loaded: the accepting edge starts the
// synchronous RAM read into the middle stage, which moves on to the output register when that is free.
// Throughput is one beat per cycle while m_tready stays high, set by the single RAM port, which serves
// one access per item.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the ROM size
// code at index 0 and the RAM size code at index 1; write only while idle.
// Reset clears the bank registers (ROM bank 1, RAM off, simple mode) and
// empties the pipeline; the RAM contents stay undefined until written.
// When m_tready is low, the output beat holds and one more beat can be
// taken into the middle stage before s_tready drops.
module rom_ram_bank_controller #(
    parameter int RAM_BANK_BITS = rrbc_pkg::RAM_BANK_BITS_DEF,
    parameter int RAM_BANKS     = rrbc_pkg::RAM_BANKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[1:0], address[17:2], write_data[25:18], zero pad
    input  logic [rrbc_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rom_address[20:0], rom_fetch[21], read_data[29:22], unmapped[30], zero pad
    output logic [rrbc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [rrbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rrbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rrbc_pkg::*;

    localparam int RAM_DEPTH = RAM_BANKS << RAM_BANK_BITS;
    localparam int RAM_IDX_W = $clog2(RAM_DEPTH);

    logic             accept;
    logic             out_free;
    logic             s1_move;
    bank_res_t        res;
    logic             ram_we;
    logic             ram_re;
    logic [RAM_IDX_W-1:0] ram_index;
    logic [7:0]       ram_rdata;

    logic             s1_valid_reg;
    bank_res_t        s1_res_reg;
    logic             m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [7:0]       read_byte;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    rrbc_bank #(
        .RAM_BANK_BITS(RAM_BANK_BITS),
        .RAM_BANKS    (RAM_BANKS),
        .IDX_W        (RAM_IDX_W)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .opcode    (op_t'(s_tdata[1:0])),
        .address   (s_tdata[17:2]),
        .write_data(s_tdata[25:18]),
        .res       (res),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_index (ram_index)
    );

    rrbc_ram #(
        .DEPTH(RAM_DEPTH),
        .IDX_W(RAM_IDX_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .re   (ram_re),
        .index(ram_index),
        .wdata(s_tdata[25:18]),
        .rdata(ram_rdata)
    );

    assign read_byte = s1_res_reg.from_ram ? ram_rdata : s1_res_reg.fixed_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_move)
        begin
            m_data_reg <= {1'b0, s1_res_reg.unmapped, read_byte,
                           s1_res_reg.rom_fetch, s1_res_reg.rom_address};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |-> !accept)
        else $error("Input beat accepted while the middle stage was blocked.");

    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("Output beat appeared without a pending access.");

    a_ram_only_on_access: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we || ram_re) |-> (accept && !(ram_we && ram_re)))
        else $error("RAM accessed outside an accepted beat.");

    a_ram_byte_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_res_reg.from_ram && !s1_move) |-> !ram_re)
        else $error("Pending RAM byte overwritten before it moved on.");
`endif

endmodule

### tb/rom_ram_bank_controller_test.sv
// Self-checking stream testbench for the ROM/RAM bank controller with a shadow predictor.
module rom_ram_bank_controller_test;
    import rrbc_pkg::*;

    localparam int RAM_BANK_BYTES = 1 << RAM_BANK_BITS_DEF;
    localparam int RAM_BANKS      = RAM_BANKS_DEF;
    localparam int RAM_BYTES      = RAM_BANK_BYTES * RAM_BANKS;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 6;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  rom_fetch;
        logic [BYTE_W-1:0]     read_data;
        logic                  unmapped;
    } access_result_t;

    class bank_shadow;
        logic [3:0]          rom_code;
        logic [2:0]          ram_code;
        bit                  ram_on;
        bit [6:0]            rom_bank;
        bit [1:0]            ram_page;
        bit                  mode;
        bit [7:0]            cart_ram [RAM_BYTES];
        bit                  stored [RAM_BYTES];
        int unsigned         stored_q[$];
        access_result_t      due_results[$];
        int                  errors;

        function new();
            rom_code = 0;
            ram_code = 0;
            ram_on   = 0;
            rom_bank = 1;
            ram_page = 0;
            mode     = 0;
            errors   = 0;
        endfunction

        function int ram_slot(logic [15:0] addr);
            int bank;
            bank = mode ? int'(ram_page) % RAM_BANKS : 0;
            return bank * RAM_BANK_BYTES + int'(addr[RAM_BANK_BITS_DEF-1:0]);
        endfunction

        function bit write_register(logic [15:0] addr, logic [7:0] data);
            int banks;
            int low;
            int up;
            banks = 2 << ((rom_code > 8) ? 8 : int'(rom_code));
            if (addr <= 16'h1fff)
            begin
                ram_on = (data[3:0] == 4'ha);
            end
            else if (addr <= 16'h3fff)
            begin
                low = int'(data[4:0]);
                if (low == 0)
                    low = 1;
                rom_bank = 7'(((int'(rom_bank) & 'h60) | low) & (banks - 1));
            end
            else if (addr <= 16'h5fff)
            begin
                if (banks > 32)
                begin
                    up = int'(data[1:0]) % (banks >> 5);
                    rom_bank = 7'((int'(rom_bank) & 'h1f) | (up << 5));
                end
                if (ram_code >= 3 && ram_code <= 5)
                    ram_page = data[1:0];
            end
            else if (addr <= 16'h7fff)
            begin
                mode = data[0];
            end
            else
            begin
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_access(op_t op, logic [15:0] addr, logic [7:0] data);
            access_result_t r;
            int bank;
            int slot;
            r = '0;
            case (op)
                OP_ROM_READ:
                begin
                    if (addr < 16'h4000)
                        bank = mode ? (int'(rom_bank) & 'h60) : 0;
                    else
                        bank = int'(rom_bank);
                    r.rom_address = ROM_ADDR_W'(bank * 'h4000 + int'(addr[13:0]));
                    r.rom_fetch = 1'b1;
                end
                OP_REG_WRITE:
                begin
                    r.unmapped = write_register(addr, data);
                end
                OP_RAM_READ:
                begin
                    r.read_data = ram_on ? cart_ram[ram_slot(addr)] : 8'hff;
                end
                OP_RAM_WRITE:
                begin
                    if (ram_on)
                    begin
                        slot = ram_slot(addr);
                        cart_ram[slot] = data;
                        if (!stored[slot])
                        begin
                            stored[slot] = 1'b1;
                            stored_q.push_back(slot);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            due_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            access_result_t want;
            if (due_results.size() == 0)
            begin
                $error("output beat %h arrived with nothing expected", beat);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (beat[20:0] !== want.rom_address)
            begin
                $error("rom_address: expected %h, got %h", want.rom_address, beat[20:0]);
                errors++;
            end
            if (beat[21] !== want.rom_fetch)
            begin
                $error("rom_fetch: expected %b, got %b", want.rom_fetch, beat[21]);
                errors++;
            end
            if (beat[29:22] !== want.read_data)
            begin
                $error("read_data: expected %h, got %h", want.read_data, beat[29:22]);
                errors++;
            end
            if (beat[30] !== want.unmapped)
            begin
                $error("unmapped: expected %b, got %b", want.unmapped, beat[30]);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    bank_shadow shadow = new();
    int         out_beats = 0;
    int         cycles = 0;
    int         calm_left = 0;
    bit         squeezed = 0;

    rom_ram_bank_controller dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            shadow.check_result(m_tdata);
            out_beats++;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus one long hold-off so the pipeline fills up.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!squeezed && out_beats >= 300)
            begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic set_sizes(logic [3:0] rom_code, logic [2:0] ram_code);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROM_SIZE;
        cfg_data  <= rom_code;
        @(posedge clk);
        cfg_index <= CFG_RAM_SIZE;
        cfg_data  <= {1'b0, ram_code};
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow.rom_code = rom_code;
        shadow.ram_code = ram_code;
    endtask

    task automatic send_access(op_t op, logic [15:0] addr, logic [7:0] data);
        int gap;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            gap = 0;
            calm_left = $urandom_range(30, 60);
        end
        else
        begin
            gap = idle_len();
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, data, addr, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        shadow.note_access(op, addr, data);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (shadow.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Picks a bus address whose byte in the currently mapped RAM bank holds data.
    function automatic bit pick_stored(output logic [15:0] addr);
        int unsigned slot;
        int want_bank;
        want_bank = shadow.mode ? int'(shadow.ram_page) % RAM_BANKS : 0;
        addr = '0;
        if (shadow.stored_q.size() == 0)
            return 1'b0;
        repeat (16)
        begin
            slot = shadow.stored_q[$urandom_range(0, shadow.stored_q.size() - 1)];
            if (int'(slot) / RAM_BANK_BYTES == want_bank)
            begin
                addr = {3'($urandom), 13'(slot)};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic random_access();
        int r;
        int region;
        logic [15:0] addr;
        logic [7:0] data;
        op_t op;
        r = $urandom_range(0, 99);
        addr = 16'($urandom);
        data = 8'($urandom);
        if (r < 25)
        begin
            op = OP_ROM_READ;
        end
        else if (r < 55)
        begin
            op = OP_REG_WRITE;
            region = $urandom_range(0, 99);
            if (region < 25)
            begin
                addr = 16'($urandom_range(0, 'h1fff));
                if ($urandom_range(0, 3) != 0)
                    data[3:0] = 4'ha;
            end
            else if (region < 50)
            begin
                addr = 16'($urandom_range('h2000, 'h3fff));
                if ($urandom_range(0, 9) == 0)
                    data[4:0] = 5'd0;
            end
            else if (region < 70)
            begin
                addr = 16'($urandom_range('h4000, 'h5fff));
            end
            else if (region < 90)
            begin
                addr = 16'($urandom_range('h6000, 'h7fff));
            end
            else
            begin
                addr = 16'($urandom_range('h8000, 'hffff));
            end
        end
        else if (r < 80)
        begin
            op = OP_RAM_READ;
            if (shadow.ram_on && !pick_stored(addr))
                op = OP_RAM_WRITE;
        end
        else
        begin
            op = OP_RAM_WRITE;
        end
        send_access(op, addr, data);
    endtask

    initial
    begin
        logic [3:0] rom_codes [6];
        logic [2:0] ram_codes [6];
        rom_codes = '{4'd0, 4'd15, 4'd8, 4'd5, 4'd6, 4'd2};
        ram_codes = '{3'd0, 3'd7, 3'd5, 3'd3, 3'd4, 3'd1};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_sizes(4'd15, 3'd3);
        send_access(OP_ROM_READ,  16'h0000, 8'h00);
        send_access(OP_ROM_READ,  16'h7fff, 8'hff);
        send_access(OP_RAM_READ,  16'ha000, 8'h00);
        send_access(OP_RAM_WRITE, 16'ha000, 8'h55);
        send_access(OP_REG_WRITE, 16'h0000, 8'h0a);
        send_access(OP_RAM_WRITE, 16'ha000, 8'ha5);
        send_access(OP_RAM_READ,  16'ha000, 8'h00);
        send_access(OP_RAM_WRITE, 16'hffff, 8'hff);
        send_access(OP_RAM_READ,  16'h1fff, 8'h00);
        send_access(OP_REG_WRITE, 16'h2000, 8'h00);
        send_access(OP_REG_WRITE, 16'h3fff, 8'h1f);
        send_access(OP_ROM_READ,  16'h4000, 8'h00);
        send_access(OP_REG_WRITE, 16'h4000, 8'h03);
        send_access(OP_ROM_READ,  16'hffff, 8'h00);
        send_access(OP_REG_WRITE, 16'h6000, 8'h01);
        send_access(OP_ROM_READ,  16'h3fff, 8'h00);
        send_access(OP_RAM_WRITE, 16'hbfff, 8'h3c);
        send_access(OP_RAM_READ,  16'hbfff, 8'h00);
        send_access(OP_REG_WRITE, 16'h8000, 8'h12);
        send_access(OP_REG_WRITE, 16'hffff, 8'hff);
        send_access(OP_REG_WRITE, 16'h7fff, 8'h00);
        send_access(OP_REG_WRITE, 16'h5fff, 8'hfc);
        send_access(OP_REG_WRITE, 16'h1fff, 8'h00);
        send_access(OP_RAM_READ,  16'h0000, 8'h00);
        send_access(OP_REG_WRITE, 16'h1000, 8'h1a);
        send_access(OP_RAM_READ,  16'h0000, 8'h00);
        send_access(OP_REG_WRITE, 16'h2000, 8'h20);
        settle();

        for (int p = 0; p < 6; p++)
        begin
            set_sizes(rom_codes[p], ram_codes[p]);
            repeat (222) random_access();
            settle();
        end

        if (shadow.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### files.f
hw/rtl/rrbc_pkg.sv
hw/rtl/rrbc_ram.sv
hw/rtl/rrbc_bank.sv
hw/rtl/rom_ram_bank_controller.sv
tb/rom_ram_bank_controller_test.sv
